// ===== rtl/cwc_pkg.sv =====
// shared types, constants and the crc word update function for the crc32 word checksum
// no dependencies

package cwc_pkg;

  localparam int CrcWidth  = 32;
  localparam int WordBits  = 32;
  localparam int CfgIdxW   = 1;

  localparam logic [CrcWidth-1:0] PolyReset = 32'h04C1_1DB7;
  localparam logic [CrcWidth-1:0] InitReset = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] CrcReset  = 32'hFFFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    RegPolynomial = 1'b0,
    RegInitValue  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CrcWidth-1:0] polynomial;
    logic [CrcWidth-1:0] initial_value;
  } cfg_t;

  typedef struct packed {
    logic [CrcWidth-1:0] data_word;
    logic                first_word;
    logic                last_word;
  } item_t;

  // msb-first update, no reflection, data aligned to the top of the register
  function automatic logic [CrcWidth-1:0] crc_absorb(
    input logic [CrcWidth-1:0] crc,
    input logic [CrcWidth-1:0] data,
    input logic [CrcWidth-1:0] poly
  );
    logic [CrcWidth-1:0] mask;
    logic [CrcWidth-1:0] c;
    mask = {CrcWidth{1'b1}} >> (CrcWidth - WordBits);
    c    = crc ^ ((data & mask) << (CrcWidth - WordBits));
    for (int i = 0; i < WordBits; i++) begin
      if (c[CrcWidth-1]) begin
        c = (c << 1) ^ poly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/cwc_cfg_regs.sv =====
// polynomial and initial value registers written through the plain write port
// depends on cwc_pkg

module cwc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cwc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [cwc_pkg::CrcWidth-1:0]     cfg_wdata_i,
  output cwc_pkg::cfg_t                    cfg_o
);

  logic [cwc_pkg::CrcWidth-1:0] poly_q, poly_d;
  logic [cwc_pkg::CrcWidth-1:0] init_q, init_d;

  always_comb begin
    poly_d = poly_q;
    init_d = init_q;
    if (cfg_we_i) begin
      unique case (cwc_pkg::cfg_reg_e'(cfg_index_i))
        cwc_pkg::RegPolynomial: poly_d = cfg_wdata_i;
        cwc_pkg::RegInitValue:  init_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= cwc_pkg::PolyReset;
      init_q <= cwc_pkg::InitReset;
    end else begin
      poly_q <= poly_d;
      init_q <= init_d;
    end
  end

  assign cfg_o.polynomial    = poly_q;
  assign cfg_o.initial_value = init_q;

endmodule

// ===== rtl/cwc_in_stage.sv =====
// input register stage: captures one item and holds it until the update stage takes it
// depends on cwc_pkg

module cwc_in_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [cwc_pkg::CrcWidth-1:0] data_word_i,
  input  logic                         first_word_i,
  input  logic                         last_word_i,
  input  logic                         advance_i,
  output logic                         item_vld_o,
  output cwc_pkg::item_t               item_o
);

  logic           vld_q, vld_d;
  cwc_pkg::item_t item_q;
  logic           accept;

  assign in_stall_o = vld_q & ~advance_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign vld_d      = accept | (vld_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data_word  <= data_word_i;
      item_q.first_word <= first_word_i;
      item_q.last_word  <= last_word_i;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

// ===== rtl/cwc_update.sv =====
// crc update stage: running crc register, one-word xor network and result register
// depends on cwc_pkg

module cwc_update (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cwc_pkg::cfg_t                cfg_i,
  input  logic                         item_vld_i,
  input  cwc_pkg::item_t               item_i,
  output logic                         advance_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [cwc_pkg::CrcWidth-1:0] crc_value_o,
  output logic                         is_final_o
);

  logic [cwc_pkg::CrcWidth-1:0] crc_q, crc_d;
  logic [cwc_pkg::CrcWidth-1:0] start_crc;
  logic [cwc_pkg::CrcWidth-1:0] res_q;
  logic                         fin_q;
  logic                         out_vld_q, out_vld_d;
  logic                         advance;

  assign advance   = item_vld_i & (~out_vld_q | ~out_stall_i);
  assign start_crc = item_i.first_word ? cfg_i.initial_value : crc_q;
  assign crc_d     = advance
                   ? cwc_pkg::crc_absorb(start_crc, item_i.data_word, cfg_i.polynomial)
                   : crc_q;
  assign out_vld_d = advance | (out_vld_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= cwc_pkg::CrcReset;
      out_vld_q <= 1'b0;
    end else begin
      crc_q     <= crc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= crc_d;
      fin_q <= item_i.last_word;
    end
  end

  assign advance_o   = advance;
  assign out_valid_o = out_vld_q;
  assign crc_value_o = res_q;
  assign is_final_o  = fin_q;

`ifndef NO_ASSERTIONS
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("result register not filled after update");

  a_res_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (res_q == crc_q))
    else $error("result differs from running crc");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(crc_q))
    else $error("crc register changed without an item");

  a_final_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (fin_q == $past(item_i.last_word)))
    else $error("final flag not carried with item");
`endif

endmodule

// ===== rtl/crc32_word_checksum_top.sv =====
// top level of the crc32 word checksum (msb first, no reflection, no final xor)
// depends on cwc_pkg, cwc_cfg_regs, cwc_in_stage, cwc_update
//
// usage
//   input channel: data_word_i, first_word_i, last_word_i with in_valid_i / in_stall_o;
//   an item is taken on a clock edge with in_valid_i high and in_stall_o low
//   output channel: crc_value_o, is_final_o with out_valid_o / out_stall_i;
//   one result per item, in order
//   first_word_i reloads the initial value before the word; is_final_o copies last_word_i
//   configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
//   (0 polynomial, 1 initial value); write only while no item is in flight
//   latency: out_valid_o rises at the clock edge after the one that takes the item
//   (input register, then the crc register and result register updated together)
//   throughput: one item per cycle; the 32-step xor network between the input
//   register and the crc register closes the loop in one cycle
//   reset: crc register 0xffffffff, polynomial 0x04c11db7, initial value 0xffffffff,
//   both channels empty
//   receiver stall: result holds, one more item waits in the input register,
//   then in_stall_o rises

module crc32_word_checksum_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cwc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cwc_pkg::CrcWidth-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [cwc_pkg::CrcWidth-1:0] data_word_i,
  input  logic                         first_word_i,
  input  logic                         last_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [cwc_pkg::CrcWidth-1:0] crc_value_o,
  output logic                         is_final_o
);

  cwc_pkg::cfg_t  cfg;
  cwc_pkg::item_t item;
  logic           item_vld;
  logic           advance;

  cwc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cwc_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .first_word_i (first_word_i),
    .last_word_i  (last_word_i),
    .advance_i    (advance),
    .item_vld_o   (item_vld),
    .item_o       (item)
  );

  cwc_update u_upd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_vld_i  (item_vld),
    .item_i      (item),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .crc_value_o (crc_value_o),
    .is_final_o  (is_final_o)
  );

endmodule

// ===== test/cwc_checker.sv =====
// result checker for the crc32 word checksum: watches config writes and both item channels,
// predicts each crc result and compares it field by field; depends on cwc_pkg
`timescale 1ns / 100ps

module cwc_checker
  import cwc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CrcWidth-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [CrcWidth-1:0] data_word_i,
  input  logic                first_word_i,
  input  logic                last_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [CrcWidth-1:0] crc_value_i,
  input  logic                is_final_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  logic [CrcWidth-1:0] poly_q;
  logic [CrcWidth-1:0] init_q;
  logic [CrcWidth-1:0] crc_q;
  logic [CrcWidth-1:0] crc_expect_q[$];
  logic                final_expect_q[$];
  int unsigned         fails;

  // one data bit at a time, feedback is old top bit xor data bit
  function automatic logic [CrcWidth-1:0] crc_after_word(
    input logic [CrcWidth-1:0] crc,
    input logic [CrcWidth-1:0] word,
    input logic [CrcWidth-1:0] poly
  );
    logic [CrcWidth-1:0] c;
    logic                fb;
    c = crc;
    for (int b = WordBits - 1; b >= 0; b--) begin
      fb = c[CrcWidth-1] ^ word[b];
      c  = {c[CrcWidth-2:0], 1'b0} ^ (fb ? poly : '0);
    end
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [CrcWidth-1:0] exp_crc;
    logic                exp_final;
    if (!rst_ni) begin
      poly_q = PolyReset;
      init_q = InitReset;
      crc_q  = CrcReset;
      crc_expect_q.delete();
      final_expect_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegPolynomial: poly_q = cfg_wdata_i;
          RegInitValue:  init_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (crc_expect_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: unexpected result crc %h final %b", $realtime, crc_value_i,
                     is_final_i);
          end
        end else begin
          exp_crc   = crc_expect_q.pop_front();
          exp_final = final_expect_q.pop_front();
          if (crc_value_i !== exp_crc || is_final_i !== exp_final) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch expected crc %h final %b, got crc %h final %b",
                       $realtime, exp_crc, exp_final, crc_value_i, is_final_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (first_word_i) begin
          crc_q = init_q;
        end
        crc_q = crc_after_word(crc_q, data_word_i, poly_q);
        crc_expect_q.push_back(crc_q);
        final_expect_q.push_back(last_word_i);
      end
    end
    fail_count_o <= fails;
    pending_o    <= crc_expect_q.size();
  end

endmodule

// ===== test/tb.sv =====
// testbench top for the crc32 word checksum: clock, reset, config writes and item stimulus
// with random idling; depends on cwc_pkg, crc32_word_checksum_top and cwc_checker
`timescale 1ns / 100ps

module tb;
  import cwc_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CrcWidth-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CrcWidth-1:0] data_word_i;
  logic                first_word_i;
  logic                last_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CrcWidth-1:0] crc_value_o;
  logic                is_final_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  crc32_word_checksum_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .first_word_i (first_word_i),
    .last_word_i  (last_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .crc_value_o  (crc_value_o),
    .is_final_o   (is_final_o)
  );

  cwc_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_word_i  (data_word_i),
    .first_word_i (first_word_i),
    .last_word_i  (last_word_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .crc_value_i  (crc_value_o),
    .is_final_i   (is_final_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_word(input logic [CrcWidth-1:0] d, input logic f, input logic l);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_word_i  <= d;
    first_word_i <= f;
    last_word_i  <= l;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CrcWidth-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic reconfigure(input logic [CrcWidth-1:0] poly, input logic [CrcWidth-1:0] init);
    drain();
    write_reg(RegPolynomial, poly);
    write_reg(RegInitValue, init);
  endtask

  function automatic logic [CrcWidth-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return CrcWidth'(1) << $urandom_range(CrcWidth - 1);
      3:       return ~(CrcWidth'(1) << $urandom_range(CrcWidth - 1));
      default: return $urandom();
    endcase
  endfunction

  task automatic run_messages(input int unsigned idle_pct, input int unsigned stall_pct,
                              input int unsigned count);
    int unsigned sent;
    int unsigned len;
    bit          framed;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < count) begin
      len    = $urandom_range(1, 8);
      framed = ($urandom_range(99) < 85);
      for (int unsigned k = 0; k < len; k++) begin
        if (framed) begin
          send_word(pick_word(), k == 0, k == len - 1);
        end else begin
          send_word(pick_word(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end
      sent += len;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = RegPolynomial;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    data_word_i    = '0;
    first_word_i   = 1'b0;
    last_word_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // no first word after reset, then a framed message, continuation and one-word messages
    send_word(32'h1234_5678, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b0);
    send_word(32'h8000_0000, 1'b0, 1'b0);
    send_word(32'h0000_0001, 1'b0, 1'b1);
    send_word(32'hA5A5_A5A5, 1'b0, 1'b0);
    send_word(32'h5A5A_5A5A, 1'b0, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(32'h0000_0000, 1'b1, 1'b1);

    reconfigure(32'hFFFF_FFFF, 32'h0000_0000);
    send_word(32'h0000_0000, 1'b1, 1'b1);
    send_word(32'h8000_0000, 1'b1, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0, 1'b1);

    // register writes leave the running crc alone
    reconfigure(32'h0000_0000, 32'hFFFF_FFFF);
    send_word(32'hDEAD_BEEF, 1'b0, 1'b0);
    send_word(32'h0000_0001, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b1);

    reconfigure(PolyReset, InitReset);
    send_word(32'h3132_3334, 1'b1, 1'b0);
    send_word(32'h3536_3738, 1'b0, 1'b0);
    send_word(32'h0000_0039, 1'b0, 1'b1);

    run_messages(0, 0, 100);
    reconfigure($urandom(), $urandom());
    run_messages(62, 0, 100);
    reconfigure(32'hFFFF_FFFF, 32'h0000_0000);
    run_messages(0, 62, 100);
    reconfigure($urandom(), 32'hFFFF_FFFF);
    run_messages(7, 7, 100);

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cwc_pkg.sv
rtl/cwc_cfg_regs.sv
rtl/cwc_in_stage.sv
rtl/cwc_update.sv
rtl/crc32_word_checksum_top.sv
test/cwc_checker.sv
test/tb.sv
